// ===== hdl/bbde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbde_pkg - shared types and constants for the energy loss evaluator
// Item, configuration and divider stage types, log constants, helpers.
// ----------------------------------------------------------------------------
package bbde_pkg;

    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;
    localparam logic [33:0] LN10_Q32    = 34'd9889527671;
    localparam logic signed [63:0] ONE_Q32_S = 64'sd4294967296;

    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_P0    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DENSITY_OFS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PLATEAU     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CUBIC       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_KNEE  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_KNEE  = 3'd5;

    typedef struct packed {
        logic [23:0]        scale_p0;
        logic [20:0]        density_offset;
        logic [19:0]        plateau_log10;
        logic [19:0]        cubic_weight;
        logic signed [20:0] lower_knee_log10;
        logic signed [20:0] upper_knee_log10;
    } bbde_cfg_t;

    localparam bbde_cfg_t CFG_RESET = '{
        scale_p0:         24'd1377510,
        density_offset:   21'd629146,
        plateau_log10:    20'd177602,
        cubic_weight:     20'd15729,
        lower_knee_log10: 21'sd122354,
        upper_knee_log10: 21'sd288098
    };

    // Classified input beat: zero flag, raw value, leading-one position and normalized mantissa of beta-gamma
    typedef struct packed {
        logic        zero;
        logic [31:0] bg;
        logic [4:0]  p1;
        logic [31:0] m1;
    } bbde_item_t;

    // One restoring division step
    typedef struct packed {
        logic               zero;
        logic               spos;
        logic signed [55:0] s;
        logic [63:0]        den;
        logic [63:0]        rem;
        logic [61:0]        q;
        logic               big;
    } bbde_div_t;

    function automatic logic [5:0] lead_one64(input logic [63:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

endpackage

// ===== hdl/bbde_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbde_fifo - small register queue
// Push/full on the write side, pop/empty on the read side.
// ----------------------------------------------------------------------------
module bbde_fifo #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && !full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("fifo count did not advance on push");
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push && !empty) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("fifo count did not drop on pop");
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("fifo full and empty together");
`endif

endmodule

// ===== hdl/bbde_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbde_front - input classification
// Flags a zero beta-gamma and normalizes it for the log pipeline.
// ----------------------------------------------------------------------------
module bbde_front (
    input  logic               push,
    input  logic [31:0]        beta_gamma,
    input  logic               queue_full,
    output logic               queue_push,
    output bbde_pkg::bbde_item_t item
);
    import bbde_pkg::*;

    logic [5:0] lead;

    always_comb
    begin
        lead      = lead_one64({32'b0, beta_gamma});
        item.zero = (beta_gamma == '0);
        item.bg   = beta_gamma;
        item.p1   = lead[4:0];
        // place the leading one at bit 31
        item.m1   = beta_gamma << (5'd31 - lead[4:0]);
    end

    assign queue_push = push & ~queue_full;

endmodule

// ===== hdl/bbde_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbde_div - pipelined restoring divider
// One quotient bit per stage; flags a quotient at or above 2^62.
// ----------------------------------------------------------------------------
module bbde_div #(
    parameter int NSTEP = 89
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  bbde_pkg::bbde_div_t din,
    output logic                out_vld,
    output bbde_pkg::bbde_div_t dout
);
    import bbde_pkg::*;

    bbde_div_t stage_reg [NSTEP];
    logic      vld_reg   [NSTEP];

    for (genvar j = 0; j < NSTEP; j++) begin : g_step
        bbde_div_t   cur, nxt;
        logic        cv, nb, ge;
        logic [64:0] r65, d65;

        if (j == 0) begin : g_first
            assign cur = din;
            assign cv  = in_vld;
        end else begin : g_rest
            assign cur = stage_reg[j-1];
            assign cv  = vld_reg[j-1];
        end

        // numerator bits enter MSB first, then zeros for the scale shift
        if (j < 53) begin : g_num
            assign nb = cur.s[52-j];
        end else begin : g_pad
            assign nb = 1'b0;
        end

        always_comb
        begin
            r65     = {cur.rem, nb};
            d65     = {1'b0, cur.den};
            ge      = (r65 >= d65);
            nxt     = cur;
            nxt.rem = ge ? 64'(r65 - d65) : r65[63:0];
            nxt.q   = {cur.q[60:0], ge};
            nxt.big = cur.big | cur.q[61];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)   vld_reg[j] <= 1'b0;
            else if (en)  vld_reg[j] <= cv;
        end

        always_ff @(posedge clk)
        begin
            if (en) stage_reg[j] <= nxt;
        end
    end

    assign dout    = stage_reg[NSTEP-1];
    assign out_vld = vld_reg[NSTEP-1];

endmodule

// ===== hdl/bbde_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbde_back - energy loss datapath
// Logs by repeated squaring, density correction, division, scale, saturate.
// ----------------------------------------------------------------------------
module bbde_back #(
    parameter int FRACTION_BITS = 18
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bbde_pkg::bbde_cfg_t  cfg,
    input  logic                 queue_empty,
    input  bbde_pkg::bbde_item_t item,
    output logic                 queue_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output logic [31:0]          res_loss,
    output logic                 res_err
);
    import bbde_pkg::*;

    localparam int NSTEP = 53 + 2 * FRACTION_BITS;
    localparam logic [63:0] ONE_SQ  = 64'd1 << (2 * FRACTION_BITS);
    localparam logic [63:0] HALF_SQ = 64'd1 << (2 * FRACTION_BITS - 1);
    localparam logic signed [7:0] S_HI  = 8'(2 * FRACTION_BITS);
    localparam logic signed [7:0] S_LO  = 8'(2 * FRACTION_BITS - 1);
    localparam logic signed [6:0] K_OFF = 7'(FRACTION_BITS);
    localparam logic signed [39:0] LN2_S   = 40'(LN2_Q32);
    localparam logic signed [39:0] LOG10_S = 40'(LOG10_2_Q32);

    typedef struct packed {
        logic        zero;
        logic [63:0] sq;
        logic [4:0]  p1;
        logic [5:0]  p2;
        logic        sflag;
        logic [31:0] m1;
        logic [31:0] m2;
        logic [31:0] fr1;
        logic [31:0] fr2;
    } lg_t;

    typedef struct packed {
        logic               zero;
        logic [63:0]        sq;
        logic signed [39:0] ln1p;
        logic               lower;
        logic               mid;
        logic [28:0]        dq;
        logic signed [41:0] base;
    } dc_t;

    logic adv;
    assign adv       = ~res_full;
    assign queue_pop = adv & ~queue_empty;

    // stage 1: square
    logic              s1_vld_reg;
    bbde_item_t        s1_reg;
    logic [63:0]       s1_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)    s1_vld_reg <= 1'b0;
        else if (adv)  s1_vld_reg <= ~queue_empty;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg    <= item;
            s1_sq_reg <= 64'(item.bg) * 64'(item.bg);
        end
    end

    // stage 2: 1 + bg^2 and its normalization
    logic        s2_vld_reg;
    lg_t         lg_in_reg;
    logic [63:0] a_val;
    logic [5:0]  a_lead;
    logic [31:0] a_mant;
    logic        a_half;

    always_comb
    begin
        a_half = s1_sq_reg[63];
        a_val  = a_half ? ({1'b0, s1_sq_reg[63:1]} + HALF_SQ) : (s1_sq_reg + ONE_SQ);
        a_lead = lead_one64(a_val);
        if (a_lead >= 6'd31) a_mant = 32'(a_val >> (a_lead - 6'd31));
        else                 a_mant = 32'(a_val << (6'd31 - a_lead));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)    s2_vld_reg <= 1'b0;
        else if (adv)  s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lg_in_reg.zero  <= s1_reg.zero;
            lg_in_reg.sq    <= s1_sq_reg;
            lg_in_reg.p1    <= s1_reg.p1;
            lg_in_reg.p2    <= a_lead;
            lg_in_reg.sflag <= a_half;
            lg_in_reg.m1    <= s1_reg.m1;
            lg_in_reg.m2    <= a_mant;
            lg_in_reg.fr1   <= '0;
            lg_in_reg.fr2   <= '0;
        end
    end

    // stages 3..34: one fraction bit of both logs per stage
    lg_t  lg_reg     [32];
    logic lg_vld_reg [32];

    for (genvar j = 0; j < 32; j++) begin : g_log
        lg_t         cur, nxt;
        logic        cv;
        logic [63:0] sq1, sq2;

        if (j == 0) begin : g_first
            assign cur = lg_in_reg;
            assign cv  = s2_vld_reg;
        end else begin : g_rest
            assign cur = lg_reg[j-1];
            assign cv  = lg_vld_reg[j-1];
        end

        always_comb
        begin
            sq1     = 64'(cur.m1) * 64'(cur.m1);
            sq2     = 64'(cur.m2) * 64'(cur.m2);
            nxt     = cur;
            nxt.m1  = sq1[63] ? sq1[63:32] : sq1[62:31];
            nxt.m2  = sq2[63] ? sq2[63:32] : sq2[62:31];
            nxt.fr1 = {cur.fr1[30:0], sq1[63]};
            nxt.fr2 = {cur.fr2[30:0], sq2[63]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)    lg_vld_reg[j] <= 1'b0;
            else if (adv)  lg_vld_reg[j] <= cv;
        end

        always_ff @(posedge clk)
        begin
            if (adv) lg_reg[j] <= nxt;
        end
    end

    // stage L: natural and decimal logs in Q.32
    lg_t                lg_last;
    logic               l_vld_reg, l_zero_reg;
    logic [63:0]        l_sq_reg;
    logic signed [39:0] l_lnbg_reg, l_l10_reg, l_ln1p_reg;
    logic signed [6:0]  k_s;
    logic signed [7:0]  e2_s;
    logic [63:0]        f1_ln2, f1_l10, f2_ln2;
    logic signed [39:0] lnbg_c, l10_c, ln1p_c;

    assign lg_last = lg_reg[31];

    always_comb
    begin
        k_s    = $signed({2'b0, lg_last.p1}) - K_OFF;
        e2_s   = $signed({2'b0, lg_last.p2}) - (lg_last.sflag ? S_LO : S_HI);
        f1_ln2 = 64'(lg_last.fr1) * 64'(LN2_Q32);
        f1_l10 = 64'(lg_last.fr1) * 64'(LOG10_2_Q32);
        f2_ln2 = 64'(lg_last.fr2) * 64'(LN2_Q32);
        lnbg_c = 40'(k_s) * LN2_S + $signed({8'b0, f1_ln2[63:32]});
        l10_c  = 40'(k_s) * LOG10_S + $signed({8'b0, f1_l10[63:32]});
        ln1p_c = 40'(e2_s) * LN2_S + $signed({8'b0, f2_ln2[63:32]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)    l_vld_reg <= 1'b0;
        else if (adv)  l_vld_reg <= lg_vld_reg[31];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_zero_reg <= lg_last.zero;
            l_sq_reg   <= lg_last.sq;
            l_lnbg_reg <= lnbg_c;
            l_l10_reg  <= l10_c;
            l_ln1p_reg <= ln1p_c;
        end
    end

    // stage D1: region select, plateau term, cubic distance
    logic               d1_vld_reg;
    dc_t                d1_reg;
    logic signed [39:0] lo40, up40, diff;
    logic [53:0]        plat_p;
    dc_t                d1_next;

    always_comb
    begin
        lo40           = 40'($signed({cfg.lower_knee_log10, 16'b0}));
        up40           = 40'($signed({cfg.upper_knee_log10, 16'b0}));
        diff           = up40 - l_l10_reg;
        plat_p         = 54'(cfg.plateau_log10) * 54'(LN10_Q32);
        d1_next.zero   = l_zero_reg;
        d1_next.sq     = l_sq_reg;
        d1_next.ln1p   = l_ln1p_reg;
        d1_next.lower  = (l_l10_reg < lo40);
        d1_next.mid    = (l_l10_reg < up40);
        d1_next.dq     = diff[36:8];
        d1_next.base   = $signed({3'b0, plat_p[53:15]}) - (42'(l_lnbg_reg) <<< 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)    d1_vld_reg <= 1'b0;
        else if (adv)  d1_vld_reg <= l_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv) d1_reg <= d1_next;
    end

    // stages D2..D4: square, cube, weight
    logic        d2_vld_reg, d3_vld_reg, d4_vld_reg;
    dc_t         d2_reg, d3_reg, d4_reg;
    logic [33:0] d2_sq24_reg;
    logic [38:0] d3_cube_reg;
    logic [50:0] d4_cterm_reg;
    logic [57:0] sq_p;
    logic [62:0] cube_p;
    logic [58:0] cterm_p;

    always_comb
    begin
        sq_p    = 58'(d1_reg.dq) * 58'(d1_reg.dq);
        cube_p  = 63'(d2_sq24_reg) * 63'(d2_reg.dq);
        cterm_p = 59'(cfg.cubic_weight) * 59'(d3_cube_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d2_vld_reg <= 1'b0;
            d3_vld_reg <= 1'b0;
            d4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            d2_vld_reg <= d1_vld_reg;
            d3_vld_reg <= d2_vld_reg;
            d4_vld_reg <= d3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d2_reg       <= d1_reg;
            d2_sq24_reg  <= sq_p[57:24];
            d3_reg       <= d2_reg;
            d3_cube_reg  <= cube_p[62:24];
            d4_reg       <= d3_reg;
            d4_cterm_reg <= cterm_p[58:8];
        end
    end

    // stage D5: sum S and load the divider
    logic               d5_vld_reg;
    bbde_div_t          d5_reg;
    logic signed [52:0] dfq;
    logic signed [55:0] s_sum;
    bbde_div_t          d5_next;

    always_comb
    begin
        if (d4_reg.lower)
            dfq = '0;
        else
            dfq = 53'(d4_reg.base) - (d4_reg.mid ? $signed({2'b0, d4_cterm_reg}) : 53'sd0);
        s_sum = 56'($signed({1'b0, cfg.density_offset, 16'b0})) + 56'(d4_reg.ln1p)
              + 56'(dfq);
        d5_next.zero = d4_reg.zero;
        d5_next.spos = ~s_sum[55] & (s_sum != '0);
        d5_next.s    = s_sum;
        d5_next.den  = d4_reg.sq;
        d5_next.rem  = '0;
        d5_next.q    = '0;
        d5_next.big  = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)    d5_vld_reg <= 1'b0;
        else if (adv)  d5_vld_reg <= d4_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv) d5_reg <= d5_next;
    end

    logic      dv_vld;
    bbde_div_t dv;

    bbde_div #(
        .NSTEP (NSTEP)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (d5_vld_reg),
        .din     (d5_reg),
        .out_vld (dv_vld),
        .dout    (dv)
    );

    // stage X: (1 + 1/bg^2) * S - 1
    logic               x_vld_reg, x_zero_reg, x_neg_reg, x_big_reg;
    logic signed [63:0] x_val_reg;
    logic signed [63:0] x_c;

    assign x_c = 64'(dv.s) + $signed({2'b0, dv.q}) - ONE_Q32_S;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)    x_vld_reg <= 1'b0;
        else if (adv)  x_vld_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_zero_reg <= dv.zero;
            x_neg_reg  <= ~dv.spos | (~dv.big & x_c[63]);
            x_big_reg  <= dv.spos & dv.big;
            x_val_reg  <= x_c;
        end
    end

    // stage M: scale by p0 in two halves
    logic        m_vld_reg, m_zero_reg, m_neg_reg, m_big_reg;
    logic [55:0] m_ph_reg, m_pl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)    m_vld_reg <= 1'b0;
        else if (adv)  m_vld_reg <= x_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_zero_reg <= x_zero_reg;
            m_neg_reg  <= x_neg_reg;
            m_big_reg  <= x_big_reg;
            m_ph_reg   <= 56'(x_val_reg[63:32]) * 56'(cfg.scale_p0);
            m_pl_reg   <= 56'(x_val_reg[31:0]) * 56'(cfg.scale_p0);
        end
    end

    // final combine and saturation
    logic [87:0] prod;
    logic        ovf;

    always_comb
    begin
        prod = {m_ph_reg, 32'b0} + 88'(m_pl_reg);
        ovf  = |prod[87:64];
        if (m_zero_reg)
        begin
            res_loss = '1;
            res_err  = 1'b1;
        end
        else if (cfg.scale_p0 == '0)
        begin
            res_loss = '0;
            res_err  = 1'b0;
        end
        else if (m_neg_reg)
        begin
            res_loss = '0;
            res_err  = 1'b1;
        end
        else if (m_big_reg || ovf)
        begin
            res_loss = '1;
            res_err  = 1'b1;
        end
        else
        begin
            res_loss = prod[63:32];
            res_err  = 1'b0;
        end
    end

    assign res_push = adv & m_vld_reg;

endmodule

// ===== hdl/bethe_bloch_dedx_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bethe_bloch_dedx_eval - parametrised mean energy loss evaluator
// Bethe-Bloch form with a three-region density correction, one result per beat.
//
//   channel  direction  handshake            payload
//   input    in         push / full          beta_gamma
//   result   out        pop / empty          energy_loss, range_error
//   config   in         cfg_write            cfg_index, cfg_data
//
// One beat per cycle sustained while the result queue has room; results pass
// through the 32-stage log squaring chain and the one-bit-per-stage divider of
// 53 + 2*FRACTION_BITS stages.
// Reset clears the queues and pipeline valids and loads the register defaults.
// A full result queue freezes the datapath; the input queue then fills and
// raises full.
// ----------------------------------------------------------------------------
module bethe_bloch_dedx_eval #(
    parameter int FRACTION_BITS = 18
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [31:0]                      beta_gamma,
    output logic                             empty,
    input  logic                             pop,
    output logic [31:0]                      energy_loss,
    output logic                             range_error,
    input  logic                             cfg_write,
    input  logic [bbde_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bbde_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bbde_pkg::*;

    localparam int ITEM_W = $bits(bbde_item_t);

    bbde_cfg_t   cfg_reg;
    bbde_item_t  front_item, back_item;
    logic [ITEM_W-1:0] mid_rdata;
    logic        mid_push, mid_pop, mid_empty;
    logic        res_push, res_full, res_err;
    logic [31:0] res_loss;
    logic [32:0] res_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SCALE_P0:    cfg_reg.scale_p0         <= cfg_data;
                REG_DENSITY_OFS: cfg_reg.density_offset   <= cfg_data[20:0];
                REG_PLATEAU:     cfg_reg.plateau_log10    <= cfg_data[19:0];
                REG_CUBIC:       cfg_reg.cubic_weight     <= cfg_data[19:0];
                REG_LOWER_KNEE:  cfg_reg.lower_knee_log10 <= $signed(cfg_data[20:0]);
                REG_UPPER_KNEE:  cfg_reg.upper_knee_log10 <= $signed(cfg_data[20:0]);
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    bbde_front u_front (
        .push       (push),
        .beta_gamma (beta_gamma),
        .queue_full (full),
        .queue_push (mid_push),
        .item       (front_item)
    );

    bbde_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (4)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (front_item),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign back_item = bbde_item_t'(mid_rdata);

    bbde_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (mid_empty),
        .item        (back_item),
        .queue_pop   (mid_pop),
        .res_full    (res_full),
        .res_push    (res_push),
        .res_loss    (res_loss),
        .res_err     (res_err)
    );

    bbde_fifo #(
        .WIDTH (33),
        .DEPTH (4)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata ({res_loss, res_err}),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign energy_loss = res_rdata[32:1];
    assign range_error = res_rdata[0];

endmodule

// ===== verif/bethe_bloch_dedx_eval_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bethe_bloch_dedx_eval_checker - energy loss predictor and result scoreboard
// Watches the input, result and register ports of the evaluator, keeps its own
// copy of the registers, computes the expected energy loss and error flag for
// every accepted input beat and compares each popped result with the oldest one.
// ----------------------------------------------------------------------------
module bethe_bloch_dedx_eval_checker #(
    parameter int FB = 18
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic                             full,
    input  logic [31:0]                      beta_gamma,
    input  logic                             empty,
    input  logic                             pop,
    input  logic [31:0]                      energy_loss,
    input  logic                             range_error,
    input  logic                             cfg_write,
    input  logic [bbde_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bbde_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               errors,
    output int                               pending
);
    import bbde_pkg::*;

    typedef struct packed {
        logic [31:0] loss;
        logic        err;
    } dedx_t;

    bbde_cfg_t regs;
    dedx_t     dedx_q[$];

    assign pending = dedx_q.size();

    // 32 fraction bits of log2(v) by repeated squaring; ip gets the integer part
    function automatic logic [31:0] log2_frac(input logic [63:0] v, output int ip);
        int          p;
        logic [63:0] m;
        logic [31:0] fr;
        p = 0;
        for (int i = 0; i < 64; i++)
            if (v[i]) p = i;
        if (p >= 31) m = v >> (p - 31);
        else m = v << (31 - p);
        fr = '0;
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            fr = {fr[30:0], 1'b0};
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                fr[0] = 1'b1;
            end
        end
        ip = p;
        return fr;
    endfunction

    function automatic longint scaled_log(input int k, input logic [31:0] fr,
                                          input logic [63:0] c);
        logic [63:0] t;
        t = ({32'b0, fr} * c) >> 32;
        return longint'(k) * longint'(c) + longint'(t);
    endfunction

    // floor(num * 2^sh / den), stops early once the quotient reaches 2^62
    function automatic logic [63:0] div_scaled(input logic [63:0] num, input int sh,
                                               input logic [63:0] den, output bit big);
        logic [63:0] q, rem;
        logic        b, top;
        q = '0;
        rem = '0;
        big = 1'b0;
        for (int i = 53 + sh - 1; i >= 0; i--) begin
            b = (i >= sh) ? num[i - sh] : 1'b0;
            top = rem[63];
            rem = {rem[62:0], b};
            q = q << 1;
            if (top || rem >= den) begin
                rem = rem - den;
                q[0] = 1'b1;
            end
            if (q >= 64'h4000_0000_0000_0000) begin
                big = 1'b1;
                return q;
            end
        end
        return q;
    endfunction

    function automatic dedx_t dedx_of(input logic [31:0] bg, input bbde_cfg_t c);
        dedx_t       r;
        logic [31:0] fr;
        logic [63:0] sq, a, t, dq, sq24, cube, p0;
        int          p, s;
        longint      lnbg, l10, ln1p, lo, up, dfq, sum, x;
        bit          big;
        big = 1'b0;
        if (bg == 0) begin
            r.loss = 32'hFFFF_FFFF;
            r.err = 1'b1;
            return r;
        end
        fr = log2_frac({32'b0, bg}, p);
        lnbg = scaled_log(p - FB, fr, {32'b0, LN2_Q32});
        l10 = scaled_log(p - FB, fr, {32'b0, LOG10_2_Q32});
        sq = {32'b0, bg} * {32'b0, bg};
        if (sq[63]) begin
            a = (sq >> 1) + (64'd1 << (2 * FB - 1));
            s = 2 * FB - 1;
        end
        else begin
            a = sq + (64'd1 << (2 * FB));
            s = 2 * FB;
        end
        fr = log2_frac(a, p);
        ln1p = scaled_log(p - s, fr, {32'b0, LN2_Q32});
        lo = longint'($signed(c.lower_knee_log10)) * 64'sd65536;
        up = longint'($signed(c.upper_knee_log10)) * 64'sd65536;
        if (l10 < lo) dfq = 0;
        else begin
            t = 64'(c.plateau_log10) * 64'(LN10_Q32);
            dfq = -2 * lnbg + longint'(t >> 15);
            if (l10 < up) begin
                dq = up - l10;
                dq = dq >> 8;
                sq24 = (dq * dq) >> 24;
                cube = (sq24 * dq) >> 24;
                t = (64'(c.cubic_weight) * cube) >> 8;
                dfq = dfq - longint'(t);
            end
        end
        sum = longint'(64'(c.density_offset) << 16) + ln1p + dfq;
        if (sum <= 0) x = -1;
        else begin
            t = div_scaled(sum, 2 * FB, sq, big);
            x = big ? 0 : sum + longint'(t) - ONE_Q32_S;
        end
        p0 = 64'(c.scale_p0);
        if (p0 == 0) begin
            r.loss = '0;
            r.err = 1'b0;
        end
        else if (!big && x < 0) begin
            r.loss = '0;
            r.err = 1'b1;
        end
        else if (big || 64'(x) > (64'hFFFF_FFFF_FFFF_FFFF / p0)) begin
            r.loss = 32'hFFFF_FFFF;
            r.err = 1'b1;
        end
        else begin
            t = (64'(x) * p0) >> 32;
            r.loss = t[31:0];
            r.err = 1'b0;
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
        $display("%0t mismatch: %s expected %h got %h", $realtime, what, want, got);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        dedx_t want;
        if (!rst_n) begin
            regs <= CFG_RESET;
            dedx_q.delete();
            errors = 0;
        end
        else begin
            if (push && !full)
                dedx_q.push_back(dedx_of(beta_gamma, regs));
            if (pop && !empty) begin
                if (dedx_q.size() == 0)
                    report("result beat with nothing pending", 64'd0,
                           64'({range_error, energy_loss}));
                else begin
                    want = dedx_q.pop_front();
                    if (energy_loss !== want.loss)
                        report("energy_loss", 64'(want.loss), 64'(energy_loss));
                    if (range_error !== want.err)
                        report("range_error", 64'(want.err), 64'(range_error));
                end
            end
            if (cfg_write) begin
                case (cfg_index)
                    REG_SCALE_P0:    regs.scale_p0 <= cfg_data[23:0];
                    REG_DENSITY_OFS: regs.density_offset <= cfg_data[20:0];
                    REG_PLATEAU:     regs.plateau_log10 <= cfg_data[19:0];
                    REG_CUBIC:       regs.cubic_weight <= cfg_data[19:0];
                    REG_LOWER_KNEE:  regs.lower_knee_log10 <= cfg_data[20:0];
                    REG_UPPER_KNEE:  regs.upper_knee_log10 <= cfg_data[20:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== verif/bethe_bloch_dedx_eval_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bethe_bloch_dedx_eval_tb - stimulus and verdict for the energy loss evaluator
// Directed beta-gamma beats at reset settings, then random beats over several
// register settings (extremes, reversed knees, negative and random curves),
// with random idling on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module bethe_bloch_dedx_eval_tb;
    import bbde_pkg::*;

    localparam int LATENCY    = 96 + 2 * 18;
    localparam int IDLE_LIMIT = 5000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic [31:0]            beta_gamma = '0;
    logic                   pop = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   full, empty, range_error;
    logic [31:0]            energy_loss;
    int                     errors, pending;
    int                     phase = 0;
    int                     quiet_cycles = 0;

    always #1 clk = ~clk;

    bethe_bloch_dedx_eval #(.FRACTION_BITS(18)) u_top (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .beta_gamma(beta_gamma),
        .empty(empty), .pop(pop), .energy_loss(energy_loss), .range_error(range_error),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bethe_bloch_dedx_eval_checker #(.FB(18)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .beta_gamma(beta_gamma),
        .empty(empty), .pop(pop), .energy_loss(energy_loss), .range_error(range_error),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // Result side: random stalls, one long hold in phase 3, no stalls in phase 5
    initial begin
        int  hold;
        bit  held;
        hold = 0;
        held = 0;
        forever begin
            @(negedge clk);
            if (phase == 3 && !held) begin
                held = 1;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end
            else
                pop <= (phase == 5) || ($urandom_range(0, 99) >= 13);
        end
    end

    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty) || cfg_write) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Present one beat and hold it until accepted; returns at a falling edge
    task automatic send_bg(input logic [31:0] v);
        logic stalled;
        push <= 1'b1;
        beta_gamma <= v;
        do begin
            stalled = full;
            @(negedge clk);
        end while (stalled);
        if (phase != 4 && $urandom_range(0, 99) < 13) begin
            push <= 1'b0;
            beta_gamma <= $urandom;
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 20) @(negedge clk);
    endtask

    // Spread over all magnitudes, with zeros and beats near the default lower knee
    function automatic logic [31:0] random_bg();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1, 2, 3: return $urandom;
            4, 5, 6, 7: return $urandom >> $urandom_range(0, 31);
            8:       return 32'd1 << $urandom_range(0, 31);
            default: return 32'd19293798 + $urandom_range(0, 2000) - 32'd1000;
        endcase
    endfunction

    task automatic load_regs(input logic [23:0] p0, input logic [23:0] d,
                             input logic [23:0] e, input logic [23:0] f,
                             input logic [23:0] lo, input logic [23:0] up);
        write_reg(REG_SCALE_P0, p0);
        write_reg(REG_DENSITY_OFS, d);
        write_reg(REG_PLATEAU, e);
        write_reg(REG_CUBIC, f);
        write_reg(REG_LOWER_KNEE, lo);
        write_reg(REG_UPPER_KNEE, up);
    endtask

    initial begin
        logic [31:0] directed[] = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd16, 32'h0002_0000, 32'h0004_0000,
            32'd19293797, 32'd19293798, 32'd19293799, 32'h7FFF_FFFF,
            32'h8000_0000, 32'hB504_F333, 32'hB504_F334, 32'hB504_F335,
            32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
        };
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[i]) send_bg(directed[i]);
        for (int ph = 1; ph <= 6; ph++) begin
            drain();
            phase = ph;
            case (ph)
                1: begin
                    load_regs(24'hFFFFFF, 24'h1FFFFF, 24'hFFFFF, 24'hFFFFF,
                              24'h100000, 24'h0FFFFF);
                    write_reg(3'd6, 24'($urandom));
                    write_reg(3'd7, 24'hFFFFFF);
                end
                2: load_regs(24'd0, 24'd0, 24'd0, 24'd0, 24'h0FFFFF, 24'h100000);
                // low offset, strong cubic: drives the sum negative
                3: load_regs(24'd1377510, 24'd0, 24'd0, 24'hFFFFF,
                             24'h1F0000, 24'd65536);
                6: load_regs(24'hFFFFFF, 24'd629146, 24'd177602, 24'd15729,
                             24'h1E0000, 24'd20000);
                default: load_regs(24'($urandom), 24'($urandom), 24'($urandom),
                                   24'($urandom), 24'($urandom), 24'($urandom));
            endcase
            // the long result hold needs more beats than the pipeline holds
            for (int n = 0; n < ((ph == 3) ? 200 : 77); n++) send_bg(random_bg());
        end
        drain();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
